// ----- hdl/sss_pkg.sv -----
// SQL statement splitter package: character codes, whitespace store sizing,
// controller states and the command/status bundles between ctrl and datapath.
// No dependencies.
package sss_pkg;

  // Depth of the trailing whitespace store
  localparam int SPACE_DEPTH = 16;
  localparam int SPACE_CW    = $clog2(SPACE_DEPTH + 1);
  localparam int SPACE_AW    = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

  // Character codes the lexer looks at
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Pending lookahead byte, one-hot as in the lookahead flags
  typedef enum logic [3:0] {
    LA_NONE  = 4'b0000,
    LA_DASH  = 4'b0001,
    LA_SLASH = 4'b0010,
    LA_STAR  = 4'b0100,
    LA_QUOTE = 4'b1000
  } la_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SPACE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;        // latch the input item and decode it
    logic push_space;  // absorb the current pushed byte as whitespace
    logic load_held;   // current pushed byte becomes the held byte
    logic emit_held;   // send the held byte
    logic emit_last;   // the held byte being sent ends the statement
    logic emit_space;  // send the oldest stored whitespace byte
    logic finish;      // close the statement
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic have_push;     // a pushed byte is still to be handled
    logic push_is_space; // that byte is whitespace
    logic more_after;    // more work follows the current pushed byte
    logic end_pending;   // the item ends a statement
    logic held_valid;    // statement has content held back
    logic flush_zero;    // no whitespace to send before the next held byte
    logic space_last;    // one whitespace byte left to send
    logic out_free;      // output register can take a result
  } status_t;

endpackage

// ----- hdl/sss_text_if.sv -----
// Input channel of the SQL statement splitter: one text byte per transfer.
// No dependencies.
interface sss_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ----- hdl/sss_stmt_if.sv -----
// Output channel of the SQL statement splitter: one statement byte per transfer.
// No dependencies.
interface sss_stmt_if;
  logic       valid;
  logic       ready;
  logic [7:0] stmt_byte;
  logic       stmt_last;
  logic       space_dropped;

  modport source (output valid, output stmt_byte, output stmt_last, output space_dropped,
                  input ready);
  modport sink (input valid, input stmt_byte, input stmt_last, input space_dropped,
                output ready);
endinterface

// ----- hdl/sss_ctrl.sv -----
// Controller of the SQL statement splitter: sequences the pushes, whitespace
// flushes and statement ends of one item. Depends on sss_pkg.
module sss_ctrl import sss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output cmd_t    cmd,
  input  status_t st
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (st.have_push) begin
          if (st.push_is_space || !st.held_valid) begin
            state_next = st.more_after ? ST_RUN : ST_IDLE;
          end else if (st.out_free) begin
            if (st.flush_zero) state_next = st.more_after ? ST_RUN : ST_IDLE;
            else state_next = ST_SPACE;
          end
        end else if (st.end_pending) begin
          if (!st.held_valid || st.out_free) state_next = ST_IDLE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SPACE: begin
        if (st.out_free && st.space_last) state_next = st.more_after ? ST_RUN : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_RUN: begin
        if (st.have_push) begin
          if (st.push_is_space) begin
            cmd.push_space = 1'b1;
          end else if (!st.held_valid) begin
            cmd.load_held = 1'b1;
          end else if (st.out_free) begin
            cmd.emit_held = 1'b1;
            cmd.load_held = st.flush_zero;
          end
        end else if (st.end_pending) begin
          if (!st.held_valid) begin
            cmd.finish = 1'b1;
          end else if (st.out_free) begin
            cmd.emit_held = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.finish    = 1'b1;
          end
        end
      end
      ST_SPACE: begin
        if (st.out_free) begin
          cmd.emit_space = 1'b1;
          cmd.load_held  = st.space_last;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_held || cmd.emit_space) |-> st.out_free)
    else $error("result sent while output register is occupied");
  a_space_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SPACE) |-> st.held_valid)
    else $error("whitespace flush without a held byte");
  a_space_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.push_space |-> !(cmd.emit_held || cmd.load_held || cmd.finish))
    else $error("whitespace absorb combined with another command");
`endif

endmodule

// ----- hdl/sss_datapath.sv -----
// Datapath of the SQL statement splitter: quote/comment lexer, held byte,
// whitespace store and output register. Depends on sss_pkg and sss_stmt_if.
module sss_datapath import sss_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    text_byte,
  input  logic          end_of_text,
  input  cmd_t          cmd,
  output status_t       st,
  sss_stmt_if.source    stmt_out
);

  typedef struct packed {
    logic in_single;
    logic in_double;
    logic in_line;
    logic in_block;
    la_t  la;
  } lex_t;

  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
  } push_list_t;

  function automatic push_list_t add_push(push_list_t l, logic [7:0] b);
    push_list_t r;
    r = l;
    if (l.n == 2'd0) begin
      r.b0 = b;
      r.n  = 2'd1;
    end else begin
      r.b1 = b;
      r.n  = 2'd2;
    end
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  lex_t                lex, lex_next;
  push_list_t          pl;
  logic                end_req;
  logic                used;
  logic                trunc_next;

  logic [1:0]          ev_n;
  logic [1:0]          ev_sel;
  logic [7:0]          ev_b0, ev_b1;
  logic                ev_end;
  logic                trunc;
  logic [7:0]          cur_byte;

  logic [7:0]          held_byte;
  logic                held_valid;
  logic [7:0]          spaces [SPACE_DEPTH];
  logic [SPACE_CW-1:0] space_count;
  logic [SPACE_CW-1:0] flush_len;
  logic                overflow_seen;

  logic                out_valid;
  logic                emit;

  // Decode one input byte: settle the pending byte, take the new one, close at end of text
  always_comb begin
    lex_next = lex;
    lex_next.la = LA_NONE;
    used     = 1'b0;
    pl       = '0;
    end_req  = 1'b0;
    case (lex.la)
      LA_DASH: begin
        if (text_byte == CH_DASH) begin
          lex_next.in_line = 1'b1;
          used = 1'b1;
        end else begin
          pl = add_push(pl, CH_DASH);
        end
      end
      LA_SLASH: begin
        if (text_byte == CH_STAR) begin
          lex_next.in_block = 1'b1;
          used = 1'b1;
        end else begin
          pl = add_push(pl, CH_SLASH);
        end
      end
      LA_STAR: begin
        if (text_byte == CH_SLASH) begin
          lex_next.in_block = 1'b0;
          used = 1'b1;
        end
      end
      LA_QUOTE: begin
        if (text_byte == CH_QUOTE) begin
          pl = add_push(pl, CH_QUOTE);
          pl = add_push(pl, CH_QUOTE);
          used = 1'b1;
        end else begin
          lex_next.in_single = 1'b0;
          pl = add_push(pl, CH_QUOTE);
        end
      end
      default: ;
    endcase

    if (!used) begin
      if (lex_next.in_line) begin
        if (text_byte == CH_NL) begin
          lex_next.in_line = 1'b0;
          pl = add_push(pl, text_byte);
        end
      end else if (lex_next.in_block) begin
        if (text_byte == CH_STAR) lex_next.la = LA_STAR;
      end else if (!lex_next.in_single && !lex_next.in_double && text_byte == CH_DASH) begin
        lex_next.la = LA_DASH;
      end else if (!lex_next.in_single && !lex_next.in_double && text_byte == CH_SLASH) begin
        lex_next.la = LA_SLASH;
      end else if (!lex_next.in_single && !lex_next.in_double && text_byte == CH_SEMI) begin
        end_req = 1'b1;
      end else if (text_byte == CH_QUOTE && !lex_next.in_double) begin
        if (lex_next.in_single) begin
          lex_next.la = LA_QUOTE;
        end else begin
          lex_next.in_single = 1'b1;
          pl = add_push(pl, text_byte);
        end
      end else if (text_byte == CH_DQUOTE && !lex_next.in_single) begin
        lex_next.in_double = !lex_next.in_double;
        pl = add_push(pl, text_byte);
      end else begin
        pl = add_push(pl, text_byte);
      end
    end

    // End of text: a lone pending byte settles as plain text, then everything resets
    if (end_of_text) begin
      case (lex_next.la)
        LA_DASH:  pl = add_push(pl, CH_DASH);
        LA_SLASH: pl = add_push(pl, CH_SLASH);
        LA_QUOTE: pl = add_push(pl, CH_QUOTE);
        default: ;
      endcase
      end_req  = 1'b1;
      lex_next = '0;
    end

    // Full run flushed, then two more bytes and the statement end: one byte too many
    trunc_next = end_req && (pl.n == 2'd2) && !is_space(pl.b0) && !is_space(pl.b1) &&
                 held_valid && (space_count == SPACE_CW'(SPACE_DEPTH));
  end

  assign cur_byte  = ev_sel[0] ? ev_b1 : ev_b0;
  // Shorten only the full run that the first push flushes
  assign flush_len = space_count - SPACE_CW'(trunc && (space_count != '0));
  assign emit      = cmd.emit_held | cmd.emit_space;

  // Status toward the controller
  always_comb begin
    st.have_push     = (ev_n == 2'd2 && ev_sel != 2'd2) || (ev_n == 2'd1 && ev_sel == 2'd0);
    st.push_is_space = is_space(cur_byte);
    st.more_after    = (ev_n == 2'd2 && ev_sel == 2'd0) || ev_end;
    st.end_pending   = ev_end;
    st.held_valid    = held_valid;
    st.flush_zero    = (flush_len == '0);
    st.space_last    = (flush_len == SPACE_CW'(1));
    st.out_free      = !out_valid || stmt_out.ready;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      lex           <= '0;
      ev_sel        <= '0;
      held_valid    <= 1'b0;
      space_count   <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.take) begin
        lex    <= lex_next;
        ev_sel <= '0;
      end
      if (cmd.push_space || cmd.load_held) ev_sel <= ev_sel + 2'd1;
      // Absorb whitespace after the held byte; flag overflow beyond the store
      if (cmd.push_space && held_valid) begin
        if (space_count < SPACE_CW'(SPACE_DEPTH)) space_count <= space_count + SPACE_CW'(1);
        else overflow_seen <= 1'b1;
      end
      if (cmd.emit_space && !cmd.load_held) space_count <= space_count - SPACE_CW'(1);
      if (cmd.load_held) begin
        held_valid    <= 1'b1;
        space_count   <= '0;
        overflow_seen <= 1'b0;
      end
      if (cmd.finish) begin
        held_valid    <= 1'b0;
        space_count   <= '0;
        overflow_seen <= 1'b0;
      end
      if (emit) out_valid <= 1'b1;
      else if (stmt_out.ready) out_valid <= 1'b0;
    end
  end

  // Item events, held byte and output payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ev_n   <= pl.n;
      ev_b0  <= pl.b0;
      ev_b1  <= pl.b1;
      ev_end <= end_req;
      trunc  <= trunc_next;
    end
    if (cmd.load_held) held_byte <= cur_byte;
    if (emit) begin
      stmt_out.stmt_byte     <= cmd.emit_space ? spaces[0] : held_byte;
      stmt_out.stmt_last     <= cmd.emit_last;
      stmt_out.space_dropped <= cmd.emit_last ? trunc : (trunc | overflow_seen);
    end
  end

  // Whitespace store: write at the fill count, drain from the front
  always_ff @(posedge clk) begin
    if (cmd.emit_space) begin
      for (int i = 0; i < SPACE_DEPTH - 1; i++) spaces[i] <= spaces[i + 1];
    end else if (cmd.push_space && held_valid && space_count < SPACE_CW'(SPACE_DEPTH)) begin
      spaces[space_count[SPACE_AW-1:0]] <= cur_byte;
    end
  end

  assign stmt_out.valid = out_valid;

`ifndef NO_ASSERTIONS
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    $rose(overflow_seen) |-> (space_count == SPACE_CW'(SPACE_DEPTH)))
    else $error("overflow flagged with whitespace store not full");
  a_empty_run: assert property (@(posedge clk) disable iff (rst)
    !held_valid |-> (space_count == '0 && !overflow_seen))
    else $error("whitespace stored without a held byte");
  a_star_block: assert property (@(posedge clk) disable iff (rst)
    (lex.la == LA_STAR) |-> lex.in_block)
    else $error("pending star outside a block comment");
  a_quote_excl: assert property (@(posedge clk) disable iff (rst)
    !(lex.in_single && lex.in_double) &&
    !((lex.in_line || lex.in_block) && (lex.in_single || lex.in_double)))
    else $error("quote and comment modes overlap");
`endif

endmodule

// ----- hdl/sql_statement_splitter.sv -----
// SQL statement splitter top level: controller plus datapath.
// Depends on sss_pkg, sss_text_if, sss_stmt_if, sss_ctrl and sss_datapath.
//
// text_in carries SQL text one byte per transfer, with end_of_text on the
// final byte. stmt_out carries the statements, trimmed of leading and trailing
// whitespace, comments removed, one byte per transfer with stmt_last on the
// final byte of each. space_dropped marks results whose inner whitespace run
// lost bytes in the store of SPACE_DEPTH entries.
// One item is handled at a time: text_in.ready is high only while idle. After
// the transfer the sequencer works through each pushed byte (zero to two) in
// turn, then any statement end; a push that flushes stored whitespace sends
// those bytes one by one, and each step that sends a result waits while the
// output register is occupied. A result is written into the output register
// in the step that makes it and is valid from the next edge. Throughput is
// set by the single output register that the flush sequencer drains the
// whitespace store through.
// Reset (rst, synchronous) clears the lexer, the held byte and the output
// register; no clearing pass is needed. When stmt_out stalls, the sequencer
// holds and text_in.ready stays low until the current item is finished.
module sql_statement_splitter import sss_pkg::*; (
  input logic         clk,
  input logic         rst,
  sss_text_if.sink    text_in,
  sss_stmt_if.source  stmt_out
);

  cmd_t    cmd;
  status_t st;

  sss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text_in.valid),
    .in_ready (text_in.ready),
    .cmd      (cmd),
    .st       (st)
  );

  sss_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .text_byte   (text_in.text_byte),
    .end_of_text (text_in.end_of_text),
    .cmd         (cmd),
    .st          (st),
    .stmt_out    (stmt_out)
  );

endmodule
